// ===== rtl/lpfr_pkg.sv =====
// Shared types, constants and helpers for the LRU page frame replacer.
`default_nettype none
package lpfr_pkg;

	localparam int PAGE_W    = 31;
	localparam int STAMP_W   = 32;
	localparam int TOTAL_W   = 32;
	localparam int FIN_W     = 5;
	localparam int IDX_OUT_W = 4;

	localparam logic [FIN_W-1:0] FIN_RESET = 5'd16;

	typedef enum logic [1:0] {
		OUT_HIT     = 2'd0,
		OUT_FILL    = 2'd1,
		OUT_FAULT   = 2'd2,
		OUT_INVALID = 2'd3
	} outcome_t;

	// Scan unit control: clear accumulators, evaluate one read-back entry.
	typedef struct packed {
		logic clr;
		logic cmp;
	} scan_ctrl_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/lpfr_if.sv =====
// Request and response channel interfaces of the LRU page frame replacer.
`default_nettype none
interface lpfr_req_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] page_ref;

	modport source (output valid, output page_ref, input ready);
	modport sink   (input valid, input page_ref, output ready);
endinterface

interface lpfr_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  outcome;
	logic [3:0]  frame_index;
	logic        evicted_valid;
	logic [30:0] evicted_page;
	logic [31:0] fault_total;
	logic [31:0] counted_total;

	modport source (output valid, output outcome, output frame_index, output evicted_valid,
		output evicted_page, output fault_total, output counted_total, input ready);
	modport sink   (input valid, input outcome, input frame_index, input evicted_valid,
		input evicted_page, input fault_total, input counted_total, output ready);
endinterface
`default_nettype wire

// ===== rtl/lpfr_frame_mem.sv =====
// Frame store: page numbers and last-use stamps, one write and one read port.
`default_nettype none
module lpfr_frame_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [AW-1:0]                 waddr,
	input  wire logic [lpfr_pkg::PAGE_W-1:0]   wpage,
	input  wire logic [lpfr_pkg::STAMP_W-1:0]  wstamp,
	input  wire logic                          re,
	input  wire logic [AW-1:0]                 raddr,
	output logic      [lpfr_pkg::PAGE_W-1:0]   rpage,
	output logic      [lpfr_pkg::STAMP_W-1:0]  rstamp
);
	import lpfr_pkg::*;

	logic [PAGE_W-1:0]  page_mem  [DEPTH];
	logic [STAMP_W-1:0] stamp_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			page_mem[waddr]  <= wpage;
			stamp_mem[waddr] <= wstamp;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rpage  <= page_mem[raddr];
			rstamp <= stamp_mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lpfr_scan.sv =====
// Shared compare unit: first page match and oldest stamp over read-back frames.
`default_nettype none
module lpfr_scan #(
	parameter int AW = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lpfr_pkg::scan_ctrl_t          ctrl,
	input  wire logic [AW-1:0]                 idx,
	input  wire logic [lpfr_pkg::PAGE_W-1:0]   key,
	input  wire logic [lpfr_pkg::PAGE_W-1:0]   rd_page,
	input  wire logic [lpfr_pkg::STAMP_W-1:0]  rd_stamp,
	output logic                               hit,
	output logic      [AW-1:0]                 hit_idx,
	output logic      [AW-1:0]                 best_idx,
	output logic      [lpfr_pkg::PAGE_W-1:0]   best_page
);
	import lpfr_pkg::*;

	logic               hit_q;
	logic               have_q;
	logic [AW-1:0]      hit_idx_q;
	logic [AW-1:0]      best_idx_q;
	logic [PAGE_W-1:0]  best_page_q;
	logic [STAMP_W-1:0] best_stamp_q;
	logic               older;

	// strict less-than keeps the lowest index on a tie
	assign older = !have_q || (rd_stamp < best_stamp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			have_q <= 1'b0;
		end else if (ctrl.clr) begin
			hit_q  <= 1'b0;
			have_q <= 1'b0;
		end else if (ctrl.cmp) begin
			have_q <= 1'b1;
			if (!hit_q && rd_page == key) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.cmp) begin
			if (!hit_q && rd_page == key) begin
				hit_idx_q <= idx;
			end
			if (older) begin
				best_idx_q   <= idx;
				best_page_q  <= rd_page;
				best_stamp_q <= rd_stamp;
			end
		end
	end

	assign hit       = hit_q;
	assign hit_idx   = hit_idx_q;
	assign best_idx  = best_idx_q;
	assign best_page = best_page_q;

`ifndef SYNTH
	a_hit_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q && !ctrl.clr |=> hit_q)
		else $error("scan hit flag dropped without clear");
	a_have_after_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.cmp && !ctrl.clr |=> have_q)
		else $error("scan compare did not record a candidate");
	a_clr_resets: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clr |=> !hit_q && !have_q)
		else $error("scan clear left state behind");
`endif

endmodule
`default_nettype wire

// ===== rtl/lru_page_frame_replacer_core.sv =====
// Top level of the LRU page frame replacer: sequencer, statistics and result register.
//
//  channel | dir | payload                                                  | transfer when
//  req     | in  | page_ref (s32)                                           | valid & ready
//  rsp     | out | outcome, frame_index, evicted_valid, evicted_page,       | valid & ready
//          |     | fault_total, counted_total                               |
//  cfg     | in  | cfg_wdata = frames_in_use (5b)                           | cfg_we
//
// Scan: a valid reference is compared against its live frames after its transfer,
//   live being the number of occupied managed frames (up to 16 with 16 frames); the
//   single read port of the frame store, one frame per cycle, sets the scan length. An
//   invalid reference, or one that finds no occupied frame, skips the scan and goes
//   straight to the commit. req.ready is high only between items.
// Reset: counters, clock and fill count clear; frames_in_use returns to 16; the frame
//   store is not cleared, entries are read only after they were filled.
// Stalls: a held result blocks the final commit; no new item is taken until it commits.
`default_nettype none
module lru_page_frame_replacer_core #(
	parameter int MAX_FRAMES = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	lpfr_req_if.sink                      req,
	lpfr_rsp_if.source                    rsp,
	input  wire logic                     cfg_we,
	input  wire logic [lpfr_pkg::FIN_W-1:0] cfg_wdata
);
	import lpfr_pkg::*;

	// Frame store address width, and a counter width that also holds a frame count.
	localparam int IW      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CW      = (IW > FIN_W) ? IW : FIN_W;
	// frames_in_use cannot name more than 31 frames
	localparam int CAP_LIM = (MAX_FRAMES > 31) ? 31 : MAX_FRAMES;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t             state_q;
	logic [FIN_W-1:0]   frames_in_use_q;
	logic [FIN_W-1:0]   filled_q;
	logic [31:0]        clock_q;
	logic [TOTAL_W-1:0] fault_q;
	logic [TOTAL_W-1:0] access_q;

	// per-item context, captured at the request transfer
	logic [PAGE_W-1:0]  page_q;
	logic [STAMP_W-1:0] stamp_q;
	logic               invalid_q;
	logic               full_q;
	logic [CW-1:0]      live_q;
	logic [CW-1:0]      cnt_q;
	logic               pend_q;
	logic [IW-1:0]      pidx_q;

	// result register
	logic               rsp_valid_q;
	outcome_t           outcome_q;
	logic [IDX_OUT_W-1:0] frame_index_q;
	logic               evicted_valid_q;
	logic [PAGE_W-1:0]  evicted_page_q;
	logic [TOTAL_W-1:0] fault_total_q;
	logic [TOTAL_W-1:0] counted_total_q;

	// managed frame count and occupancy
	logic [FIN_W-1:0]   cap;
	logic               full_c;
	logic [FIN_W-1:0]   live_c;

	always_comb begin
		if (frames_in_use_q == '0) begin
			cap = FIN_W'(1);
		end else if (frames_in_use_q > FIN_W'(CAP_LIM)) begin
			cap = FIN_W'(CAP_LIM);
		end else begin
			cap = frames_in_use_q;
		end
		full_c = (filled_q >= cap);
		live_c = full_c ? cap : filled_q;
	end

	logic req_xfer;
	logic issue;
	logic fin_fire;

	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign issue     = (state_q == ST_SCAN) && (cnt_q < live_q);
	assign fin_fire  = (state_q == ST_FIN) && (!rsp_valid_q || rsp.ready);

	// frame store and scan unit
	scan_ctrl_t         sctrl;
	logic [PAGE_W-1:0]  rd_page;
	logic [STAMP_W-1:0] rd_stamp;
	logic               s_hit;
	logic [IW-1:0]      s_hit_idx;
	logic [IW-1:0]      s_best_idx;
	logic [PAGE_W-1:0]  s_best_page;

	assign sctrl.clr = req_xfer;
	assign sctrl.cmp = pend_q;

	// commit decision
	outcome_t           fin_outcome;
	logic [IW-1:0]      fin_idx;
	logic               fin_we;
	logic [TOTAL_W-1:0] fault_nx;
	logic [TOTAL_W-1:0] access_nx;

	always_comb begin
		fin_outcome = OUT_INVALID;
		fin_idx     = '0;
		fault_nx    = fault_q;
		access_nx   = access_q;
		if (invalid_q) begin
			fin_outcome = OUT_INVALID;
		end else if (s_hit) begin
			fin_outcome = OUT_HIT;
			fin_idx     = s_hit_idx;
			if (full_q) begin
				access_nx = sat_inc(access_q);
			end
		end else if (!full_q) begin
			// next free frame
			fin_outcome = OUT_FILL;
			fin_idx     = IW'(filled_q);
		end else begin
			fin_outcome = OUT_FAULT;
			fin_idx     = s_best_idx;
			access_nx   = sat_inc(access_q);
			fault_nx    = sat_inc(fault_q);
		end
		fin_we = fin_fire && !invalid_q;
	end

	lpfr_frame_mem #(
		.DEPTH (MAX_FRAMES),
		.AW    (IW)
	) u_mem (
		.clk    (clk),
		.we     (fin_we),
		.waddr  (fin_idx),
		.wpage  (page_q),
		.wstamp (stamp_q),
		.re     (issue),
		.raddr  (cnt_q[IW-1:0]),
		.rpage  (rd_page),
		.rstamp (rd_stamp)
	);

	lpfr_scan #(
		.AW (IW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (sctrl),
		.idx       (pidx_q),
		.key       (page_q),
		.rd_page   (rd_page),
		.rd_stamp  (rd_stamp),
		.hit       (s_hit),
		.hit_idx   (s_hit_idx),
		.best_idx  (s_best_idx),
		.best_page (s_best_page)
	);

	// sequencer, statistics and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			frames_in_use_q <= FIN_RESET;
			filled_q        <= '0;
			clock_q         <= '0;
			fault_q         <= '0;
			access_q        <= '0;
			pend_q          <= 1'b0;
			rsp_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				frames_in_use_q <= cfg_wdata;
			end
			pend_q <= issue;
			// a commit refills the result slot in the cycle it drains
			if (fin_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						if (req.page_ref[31] || live_c == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// last read returned and compared
					if (!issue && !pend_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_fire) begin
						state_q     <= ST_IDLE;
						fault_q     <= fault_nx;
						access_q    <= access_nx;
						if (!invalid_q) begin
							clock_q <= sat_inc(clock_q);
						end
						if (fin_outcome == OUT_FILL) begin
							filled_q <= filled_q + FIN_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			page_q    <= req.page_ref[PAGE_W-1:0];
			stamp_q   <= clock_q;
			invalid_q <= req.page_ref[31];
			full_q    <= full_c;
			live_q    <= CW'(live_c);
			cnt_q     <= '0;
		end else if (issue) begin
			cnt_q <= cnt_q + CW'(1);
		end
		pidx_q <= cnt_q[IW-1:0];
		if (fin_fire) begin
			outcome_q       <= fin_outcome;
			frame_index_q   <= IDX_OUT_W'(fin_idx);
			evicted_valid_q <= (fin_outcome == OUT_FAULT);
			evicted_page_q  <= (fin_outcome == OUT_FAULT) ? s_best_page : '0;
			fault_total_q   <= fault_nx;
			counted_total_q <= access_nx;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.outcome       = outcome_q;
	assign rsp.frame_index   = frame_index_q;
	assign rsp.evicted_valid = evicted_valid_q;
	assign rsp.evicted_page  = evicted_page_q;
	assign rsp.fault_total   = fault_total_q;
	assign rsp.counted_total = counted_total_q;

`ifndef SYNTH
	a_filled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= FIN_W'(CAP_LIM))
		else $error("fill count beyond frame store");
	a_clock_mono: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_FIN |=> clock_q == $past(clock_q))
		else $error("use clock moved outside commit");
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		fin_fire && fin_outcome == OUT_FILL |=> filled_q == $past(filled_q) + FIN_W'(1))
		else $error("fill did not advance fill count");
	a_pend_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> state_q == ST_SCAN)
		else $error("frame read returned outside scan");
`endif

endmodule
`default_nettype wire
